/* design/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int PRIO_W  = 8;
  localparam int ID_W    = 8;
  localparam int STAT_W  = 2;
  localparam int QCNT_W  = 5;

  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_REMOVE
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } fsm_state_t;

  typedef struct packed {
    op_t   opcode;
    id_t   process_id;
    prio_t priority_req;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    prio_t             entry_priority;
    id_t               entry_id;
    logic [QCNT_W-1:0] queue_count;
    prio_t             head_priority;
    id_t               head_id;
  } out_rsp_t;

  typedef struct packed {
    logic  valid;
    prio_t prio;
    id_t   id;
  } entry_t;

  typedef struct packed {
    cell_cmd_t cmd;
    prio_t     prio;
    id_t       key;
  } cell_ctrl_t;

endpackage

/* design/spq_cell.sv */
// One slot of the sorted chain: holds an entry and moves it to or from its neighbors.
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               lead,
  input  spq_pkg::entry_t    left_ent,
  input  logic               left_gt,
  input  logic               left_tok,
  input  spq_pkg::entry_t    right_ent,
  output spq_pkg::entry_t    ent_q,
  output spq_pkg::entry_t    ent_nxt,
  output logic               gt,
  output logic               tok,
  output logic               hit
);
  import spq_pkg::*;

  logic  valid_r;
  prio_t prio_r;
  id_t   id_r;
  logic  tok_r, tok_nxt;
  logic  passed_r, passed_nxt;

  assign ent_q = '{valid: valid_r, prio: prio_r, id: id_r};
  assign gt    = valid_r && (prio_r > ctrl.prio);
  assign tok   = tok_r;
  assign hit   = tok_r && valid_r && (id_r == ctrl.key);

  always_comb begin
    ent_nxt    = ent_q;
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    unique case (ctrl.cmd)
      CMD_HOLD: begin
      end
      CMD_INSERT: begin
        // The slot left of us is moving down, or this is where the new entry lands.
        if (left_gt) begin
          ent_nxt = left_ent;
        end else if ((gt || !valid_r) && left_ent.valid) begin
          ent_nxt = '{valid: 1'b1, prio: ctrl.prio, id: ctrl.key};
        end
      end
      CMD_POP: begin
        ent_nxt = right_ent;
      end
      CMD_SCAN_START: begin
        tok_nxt    = lead;
        passed_nxt = 1'b0;
      end
      CMD_SCAN_STEP: begin
        tok_nxt    = left_tok;
        passed_nxt = passed_r | tok_r;
      end
      CMD_REMOVE: begin
        // Slots from the matching one onward close the gap.
        if (!passed_r) begin
          ent_nxt = right_ent;
        end
        tok_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      valid_r  <= ent_nxt.valid;
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= ent_nxt.prio;
    id_r   <= ent_nxt.id;
  end

endmodule

/* design/sorted_priority_queue.sv */
// Top level of the sorted priority queue: cell chain, sequencer and result register.
//
// A request on the in_ channel carries an opcode, a process id and a priority.
// Enqueue places the entry before the first one with a strictly greater
// priority (equal priorities keep arrival order); dequeue pops the head;
// remove deletes the first entry with a matching id; lookup reports it.
// Each request gives exactly one response on the out_ channel with a status,
// the affected entry (zero on enqueue), the count and head entry afterwards.
// Enqueue and dequeue act on all cells at once, so their response is
// registered at the accepting edge, one request per cycle while the
// receiver keeps up. Remove and lookup walk a token down the chain one
// cell per cycle until it reaches a matching entry, an empty slot or the
// last slot; that token walk sets their rate. On an empty queue they
// respond at the accepting edge. One request is in flight at a time.
// A new request is taken when the sequencer is idle and the result register
// is empty or being emptied in the same cycle, so a stalled receiver holds
// the response in place and back-pressures the input.
// Synchronous reset empties the queue and the result register; slot
// contents are not cleared, only their valid bits.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::out_rsp_t out_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  fsm_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  id_t              key_r;
  op_t              op_r;
  logic             out_valid_r;
  out_rsp_t         out_data_r;

  cell_ctrl_t ctrl;
  logic       load_out;
  status_t    rsp_status;
  entry_t     rsp_entry;

  entry_t ent_q   [DEPTH];
  entry_t ent_nxt [DEPTH];
  logic   gt      [DEPTH];
  logic   tok     [DEPTH];
  logic   hit     [DEPTH];

  logic   accept;
  logic   full, empty;
  logic   found_any, end_any;
  entry_t hit_entry;
  logic [31:0] cnt_ext;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  // The chain of slots; slot 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_gt, left_tok;
    if (i == 0) begin : g_first
      assign left_ent = '{valid: 1'b1, prio: '0, id: '0};
      assign left_gt  = 1'b0;
      assign left_tok = 1'b0;
    end else begin : g_mid
      assign left_ent = ent_q[i-1];
      assign left_gt  = gt[i-1];
      assign left_tok = tok[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '{valid: 1'b0, prio: '0, id: '0};
    end else begin : g_inner
      assign right_ent = ent_q[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .lead      (i == 0),
      .left_ent  (left_ent),
      .left_gt   (left_gt),
      .left_tok  (left_tok),
      .right_ent (right_ent),
      .ent_q     (ent_q[i]),
      .ent_nxt   (ent_nxt[i]),
      .gt        (gt[i]),
      .tok       (tok[i]),
      .hit       (hit[i])
    );
  end

  // Token status: at most one slot holds the token, so an OR picks its entry.
  always_comb begin
    found_any = 1'b0;
    end_any   = 1'b0;
    hit_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_any = found_any | hit[i];
      end_any   = end_any | (tok[i] && !ent_q[i].valid);
      hit_entry = hit_entry | (hit[i] ? ent_q[i] : '0);
    end
    end_any = end_any | tok[DEPTH-1];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.opcode == OP_REMOVE || in_data.opcode == OP_LOOKUP)
            && !empty) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (found_any || end_any) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: cell command, count update and response contents.
  always_comb begin
    ctrl       = '{cmd: CMD_HOLD, prio: in_data.priority_req, key: key_r};
    load_out   = 1'b0;
    rsp_status = ST_OK;
    rsp_entry  = '0;
    count_nxt  = count_r;
    unique case (state_r)
      S_IDLE: begin
        ctrl.key = in_data.process_id;
        if (accept) begin
          unique case (in_data.opcode)
            OP_ENQUEUE: begin
              load_out = 1'b1;
              if (full) begin
                rsp_status = ST_FULL;
              end else begin
                ctrl.cmd  = CMD_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DEQUEUE: begin
              load_out = 1'b1;
              if (empty) begin
                rsp_status = ST_EMPTY;
              end else begin
                ctrl.cmd  = CMD_POP;
                rsp_entry = ent_q[0];
                count_nxt = count_r - 1'b1;
              end
            end
            OP_REMOVE, OP_LOOKUP: begin
              if (empty) begin
                load_out   = 1'b1;
                rsp_status = ST_NOTFOUND;
              end else begin
                ctrl.cmd = CMD_SCAN_START;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (found_any) begin
          load_out  = 1'b1;
          rsp_entry = hit_entry;
          if (op_r == OP_REMOVE) begin
            ctrl.cmd  = CMD_REMOVE;
            count_nxt = count_r - 1'b1;
          end
        end else if (end_any) begin
          load_out   = 1'b1;
          rsp_status = ST_NOTFOUND;
        end else begin
          ctrl.cmd = CMD_SCAN_STEP;
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_data.process_id;
      op_r  <= in_data.opcode;
    end
    if (load_out) begin
      out_data_r.status         <= rsp_status;
      out_data_r.entry_priority <= rsp_entry.prio;
      out_data_r.entry_id       <= rsp_entry.id;
      out_data_r.queue_count    <= cnt_ext[QCNT_W-1:0];
      out_data_r.head_priority  <= ent_nxt[0].valid ? ent_nxt[0].prio : '0;
      out_data_r.head_id        <= ent_nxt[0].valid ? ent_nxt[0].id : '0;
    end
  end

endmodule
